/* sv/fifo_with_class_histogram_defines.svh */
// assertion macros for the fifo with class histogram
// used by sv/fifo_with_class_histogram.sv, expects clk and rst_n in scope
`ifndef FIFO_WITH_CLASS_HISTOGRAM_DEFINES_SVH
`define FIFO_WITH_CLASS_HISTOGRAM_DEFINES_SVH
`ifndef SYNTHESIS
`define FWCH_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FWCH_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define FWCH_ASSERT(lbl, prop, msg)
`define FWCH_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

/* sv/fwch_pkg.sv */
// shared constants, codes and word types of the fifo with class histogram
// no dependencies
`default_nettype none
package fwch_pkg;

    localparam int QUEUE_DEPTH = 1024;
    localparam int NUM_CLASSES = 20;

    localparam int PTR_W    = $clog2(QUEUE_DEPTH);
    localparam int FILL_W   = 11;
    localparam int ID_W     = 32;
    localparam int CLASS_W  = 5;
    localparam int COUNT_W  = 32;
    localparam int REQ_W    = 2;
    localparam int STATUS_W = 2;
    localparam int CIDX_W   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH = 2'd0,
        REQ_POP  = 2'd1,
        REQ_READ = 2'd2
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_BAD_CLASS = 2'd3
    } status_t;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [CLASS_W-1:0] cls;
    } entry_t;

    typedef struct packed {
        status_t              status;
        logic [ID_W-1:0]      served_id;
        logic [CLASS_W-1:0]   served_class;
        logic [FILL_W-1:0]    occupancy;
        logic [COUNT_W-1:0]   class_count;
    } result_t;

endpackage
`default_nettype wire

/* sv/fwch_ifs.sv */
// request and result channel interfaces, valid/ready handshake
// depends on fwch_pkg
`default_nettype none
interface fwch_req_if
    import fwch_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [REQ_W-1:0]   req_type;
    logic [ID_W-1:0]    entry_id;
    logic [CLASS_W-1:0] entry_class;

    modport source (output valid, output req_type, output entry_id, output entry_class,
                    input ready);
    modport sink   (input valid, input req_type, input entry_id, input entry_class,
                    output ready);
endinterface

interface fwch_res_if
    import fwch_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     served_id;
    logic [CLASS_W-1:0]  served_class;
    logic [FILL_W-1:0]   occupancy;
    logic [COUNT_W-1:0]  class_count;

    modport source (output valid, output status, output served_id, output served_class,
                    output occupancy, output class_count, input ready);
    modport sink   (input valid, input status, input served_id, input served_class,
                    input occupancy, input class_count, output ready);
endinterface
`default_nettype wire

/* sv/fifo_with_class_histogram.sv */
// fifo of (id, class) entries with a saturating served counter per class
// depends on fwch_pkg, fwch_ifs.sv and fifo_with_class_histogram_defines.svh
//
// usage:
//   req channel takes one request word: push (id, class), pop head, or read the
//   served count of a class. res channel gives exactly one result word per
//   request with status, popped id and class, occupancy after the request and
//   the class count after the update.
//   push, read and the ignored request code finish in the accept cycle: the
//   result goes to the output register, or to the hold register if that is
//   still full; with a free output register these run at one word per cycle.
//   a pop reads the entry memory into a registered read word and then, in the
//   pop state, updates the class counter and forms the result word.
//   the output register holds a finished word while the next request is
//   taken; a second finished word waits in a hold register, and while it
//   waits req.ready is low until res.ready frees the output register.
//   reset clears pointers, fill count, class counters and the output valid;
//   the entry memory is not cleared, since a pop only reads written entries.
`default_nettype none
`include "fifo_with_class_histogram_defines.svh"
module fifo_with_class_histogram
    import fwch_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    fwch_req_if.sink   req,
    fwch_res_if.source res
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_HOLD
    } state_t;

    state_t              state_reg, state_next;
    logic [PTR_W-1:0]    head_reg, head_next;
    logic [PTR_W-1:0]    tail_reg, tail_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [COUNT_W-1:0]  counts_reg [NUM_CLASSES];
    result_t             out_reg, out_next;
    logic                out_valid_reg, out_valid_next;
    result_t             hold_reg, hold_next;

    entry_t              mem [QUEUE_DEPTH];
    entry_t              rd_entry_reg;
    entry_t              wr_entry;
    logic                mem_wr;
    logic                mem_rd;

    logic                in_fire;
    logic                out_free;
    logic                class_ok_in;
    logic [CLASS_W-1:0]  cnt_cls;
    logic                cnt_ok;
    logic [CIDX_W-1:0]   cnt_idx;
    logic [COUNT_W-1:0]  cnt_cur;
    logic [COUNT_W-1:0]  cnt_inc;
    logic                cnt_wr;
    result_t             res_next;
    logic                res_load;

    assign req.ready = (state_reg == S_IDLE);
    assign in_fire   = req.valid && req.ready;
    assign out_free  = !out_valid_reg || res.ready;

    assign class_ok_in = (req.entry_class >= CLASS_W'(1))
                      && (req.entry_class <= CLASS_W'(NUM_CLASSES));

    // one counter read port, shared by pop update and class read
    assign cnt_cls = (state_reg == S_POP) ? rd_entry_reg.cls : req.entry_class;
    assign cnt_ok  = (cnt_cls >= CLASS_W'(1)) && (cnt_cls <= CLASS_W'(NUM_CLASSES));
    assign cnt_idx = CIDX_W'(cnt_cls - CLASS_W'(1));
    assign cnt_cur = cnt_ok ? counts_reg[cnt_idx] : '0;
    assign cnt_inc = (cnt_cur == '1) ? cnt_cur : cnt_cur + COUNT_W'(1);

    assign wr_entry.id  = req.entry_id;
    assign wr_entry.cls = req.entry_class;

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        fill_next      = fill_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        hold_next      = hold_reg;
        mem_wr         = 1'b0;
        mem_rd         = 1'b0;
        cnt_wr         = 1'b0;
        res_load       = 1'b0;
        res_next       = '0;
        res_next.status = ST_OK;

        if (out_valid_reg && res.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    case (req.req_type)
                        REQ_PUSH:
                        begin
                            res_load = 1'b1;
                            if (!class_ok_in)
                            begin
                                res_next.status = ST_BAD_CLASS;
                            end
                            else if (fill_reg == FILL_W'(QUEUE_DEPTH))
                            begin
                                res_next.status = ST_FULL;
                            end
                            else
                            begin
                                mem_wr    = 1'b1;
                                tail_next = (tail_reg == PTR_W'(QUEUE_DEPTH - 1)) ?
                                            '0 : tail_reg + PTR_W'(1);
                                fill_next = fill_reg + FILL_W'(1);
                            end
                        end
                        REQ_POP:
                        begin
                            if (fill_reg == '0)
                            begin
                                res_load        = 1'b1;
                                res_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                mem_rd     = 1'b1;
                                head_next  = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ?
                                             '0 : head_reg + PTR_W'(1);
                                fill_next  = fill_reg - FILL_W'(1);
                                state_next = S_POP;
                            end
                        end
                        REQ_READ:
                        begin
                            res_load = 1'b1;
                            if (!class_ok_in)
                            begin
                                res_next.status = ST_BAD_CLASS;
                            end
                            else
                            begin
                                res_next.class_count = cnt_cur;
                            end
                        end
                        default:
                        begin
                            res_load = 1'b1;
                        end
                    endcase
                end
            end
            S_POP:
            begin
                res_load              = 1'b1;
                res_next.served_id    = rd_entry_reg.id;
                res_next.served_class = rd_entry_reg.cls;
                if (cnt_ok)
                begin
                    cnt_wr               = 1'b1;
                    res_next.class_count = cnt_inc;
                end
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    out_next       = hold_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        res_next.occupancy = fill_next;

        // finished word goes to the output register, or waits in hold
        if (res_load)
        begin
            if (out_free)
            begin
                out_next       = res_next;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            else
            begin
                hold_next  = res_next;
                state_next = S_HOLD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
            hold_reg      <= '0;
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                counts_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            fill_reg      <= fill_next;
            out_reg       <= out_next;
            out_valid_reg <= out_valid_next;
            hold_reg      <= hold_next;
            if (cnt_wr)
            begin
                counts_reg[cnt_idx] <= cnt_inc;
            end
        end
    end

    // entry store, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            mem[tail_reg] <= wr_entry;
        end
        if (mem_rd)
        begin
            rd_entry_reg <= mem[head_reg];
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.status       = out_reg.status;
    assign res.served_id    = out_reg.served_id;
    assign res.served_class = out_reg.served_class;
    assign res.occupancy    = out_reg.occupancy;
    assign res.class_count  = out_reg.class_count;

    `FWCH_ASSERT_NEVER(a_fill_bound, fill_reg > FILL_W'(QUEUE_DEPTH), "fill count above depth")
    `FWCH_ASSERT(a_empty_ptrs, (fill_reg == '0) |-> (head_reg == tail_reg), "empty ptr mismatch")
    `FWCH_ASSERT(a_pop_read, mem_rd |=> (state_reg == S_POP), "pop did not enter read state")
    `FWCH_ASSERT(a_hold_needs_out, (state_reg == S_HOLD) |-> out_valid_reg, "hold but output empty")
    `FWCH_ASSERT(a_pop_result, (state_reg == S_POP) |=> out_valid_reg, "pop result lost")

endmodule
`default_nettype wire
